// ----- rtl/sgbb_pkg.sv -----
// Shared types and constants for the sparse grid bounding box store.
package sgbb_pkg;

	localparam int GRID_W = 32;
	localparam int GRID_H = 32;
	localparam int CELLS = GRID_W * GRID_H;

	localparam int COORD_W = 5;
	localparam int VALUE_W = 32;
	localparam int XW = $clog2(GRID_W);
	localparam int YW = $clog2(GRID_H);
	localparam int AW = $clog2(CELLS);
	localparam int COL_CW = $clog2(GRID_H + 1);
	localparam int ROW_CW = $clog2(GRID_W + 1);
	localparam int TOTAL_W = $clog2(CELLS + 1);

	localparam int IN_TDATA_W = 48;
	localparam int OUT_TDATA_W = 56;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		OPK_INSERT,
		OPK_REMOVE,
		OPK_LOOKUP,
		OPK_CLEAR,
		OPK_RANGE
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic [VALUE_W-1:0]  wval;
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} back_state_t;

	typedef struct packed {
		logic                range_error;
		logic                is_empty;
		logic [COORD_W-1:0]  max_y;
		logic [COORD_W-1:0]  min_y;
		logic [COORD_W-1:0]  max_x;
		logic [COORD_W-1:0]  min_x;
		logic [VALUE_W-1:0]  read_value;
		logic                found;
	} result_t;

endpackage

// ----- rtl/sgbb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sgbb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/sgbb_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
module sgbb_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [sgbb_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               q_valid,
	output sgbb_pkg::op_t                      q_op,
	input  logic                               q_pop
);
	import sgbb_pkg::*;

	op_t        ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	op_t        op_in;
	logic [1:0] cmd;
	logic [COORD_W-1:0] xc;
	logic [COORD_W-1:0] yc;
	logic       oob;

	assign cmd = s_tdata[1:0];
	assign xc  = s_tdata[6:2];
	assign yc  = s_tdata[11:7];
	assign oob = (int'(xc) >= GRID_W) || (int'(yc) >= GRID_H);

	always_comb begin
		op_in.x    = xc;
		op_in.y    = yc;
		op_in.wval = s_tdata[43:12];
		case (cmd_t'(cmd))
			CMD_INSERT: op_in.kind = oob ? OPK_RANGE : OPK_INSERT;
			CMD_REMOVE: op_in.kind = oob ? OPK_RANGE : OPK_REMOVE;
			CMD_LOOKUP: op_in.kind = oob ? OPK_RANGE : OPK_LOOKUP;
			CMD_CLEAR:  op_in.kind = OPK_CLEAR;
			default:    op_in.kind = OPK_CLEAR;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_op     = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ----- rtl/sgbb_back.sv -----
// Back end: cell tables, occupancy counts, bounding box and the result register.
module sgbb_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  sgbb_pkg::op_t                       q_op,
	output logic                                q_pop,
	input  logic                                cfg_we,
	input  logic [sgbb_pkg::VALUE_W-1:0]        cfg_wdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output sgbb_pkg::result_t                   res
);
	import sgbb_pkg::*;

	back_state_t state_q, state_n;
	op_t         op_q;
	logic        out_valid_q;
	result_t     res_q;
	logic [VALUE_W-1:0] absent_q;

	logic [COL_CW-1:0] col_cnt_q [GRID_W];
	logic [ROW_CW-1:0] row_cnt_q [GRID_H];
	logic [GRID_H-1:0] row_ok_q;
	logic [XW-1:0]     min_x_q, max_x_q;
	logic [YW-1:0]     min_y_q, max_y_q;
	logic [TOTAL_W-1:0] total_q;

	logic [GRID_W-1:0]  vram_rdata;
	logic [VALUE_W-1:0] dram_rdata;
	logic               vram_we, dram_we;
	logic [GRID_W-1:0]  vrow, vrow_new;

	logic [XW-1:0] xi, qx;
	logic [YW-1:0] yi, qy;
	logic exec, found, addressed, ins_new, rem_hit, wipe;
	logic [COL_CW-1:0] col_dec;
	logic [ROW_CW-1:0] row_dec;
	logic [GRID_W-1:0] occ_col;
	logic [GRID_H-1:0] occ_row;
	logic [XW-1:0] col_lo, col_hi;
	logic [YW-1:0] row_lo, row_hi;
	logic [XW-1:0] min_x_n, max_x_n;
	logic [YW-1:0] min_y_n, max_y_n;
	logic [TOTAL_W-1:0] total_n;
	result_t res_n;

	assign xi = op_q.x[XW-1:0];
	assign yi = op_q.y[YW-1:0];
	assign qx = q_op.x[XW-1:0];
	assign qy = q_op.y[YW-1:0];

	always_comb begin
		state_n = state_q;
		q_pop   = 1'b0;
		exec    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// only start when the result slot will be free at exec time
				if (q_valid && (!out_valid_q || m_tready)) begin
					q_pop   = 1'b1;
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				exec    = 1'b1;
				state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	sgbb_ram #(.WIDTH(GRID_W), .DEPTH(GRID_H)) u_valid_ram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (yi),
		.wdata (vrow_new),
		.raddr (qy),
		.rdata (vram_rdata)
	);

	sgbb_ram #(.WIDTH(VALUE_W), .DEPTH(CELLS)) u_value_ram (
		.clk   (clk),
		.we    (dram_we),
		.waddr (AW'(int'(yi) * GRID_W + int'(xi))),
		.wdata (op_q.wval),
		.raddr (AW'(int'(qy) * GRID_W + int'(qx))),
		.rdata (dram_rdata)
	);

	always_comb begin
		addressed = (op_q.kind == OPK_INSERT) || (op_q.kind == OPK_REMOVE)
			|| (op_q.kind == OPK_LOOKUP);
		// a row never written since the last clear reads as empty
		vrow      = row_ok_q[yi] ? vram_rdata : '0;
		found     = addressed && vrow[xi];
		ins_new   = (op_q.kind == OPK_INSERT) && !found;
		rem_hit   = (op_q.kind == OPK_REMOVE) && found;
		wipe      = (op_q.kind == OPK_CLEAR) || (rem_hit && (total_q == TOTAL_W'(1)));
		vrow_new  = vrow;
		vrow_new[xi] = (op_q.kind == OPK_INSERT);
		vram_we   = exec && (ins_new || (rem_hit && !wipe));
		dram_we   = exec && (op_q.kind == OPK_INSERT);

		col_dec = col_cnt_q[xi] - COL_CW'(1);
		row_dec = row_cnt_q[yi] - ROW_CW'(1);
		for (int i = 0; i < GRID_W; i++) begin
			occ_col[i] = (col_cnt_q[i] != '0) && !((XW'(i) == xi) && (col_dec == '0));
		end
		for (int i = 0; i < GRID_H; i++) begin
			occ_row[i] = (row_cnt_q[i] != '0) && !((YW'(i) == yi) && (row_dec == '0));
		end
		col_lo = '0;
		col_hi = '0;
		for (int i = GRID_W - 1; i >= 0; i--) begin
			if (occ_col[i]) col_lo = XW'(i);
		end
		for (int i = 0; i < GRID_W; i++) begin
			if (occ_col[i]) col_hi = XW'(i);
		end
		row_lo = '0;
		row_hi = '0;
		for (int i = GRID_H - 1; i >= 0; i--) begin
			if (occ_row[i]) row_lo = YW'(i);
		end
		for (int i = 0; i < GRID_H; i++) begin
			if (occ_row[i]) row_hi = YW'(i);
		end

		min_x_n = min_x_q;
		max_x_n = max_x_q;
		min_y_n = min_y_q;
		max_y_n = max_y_q;
		total_n = total_q;
		if (wipe) begin
			min_x_n = '0;
			max_x_n = '0;
			min_y_n = '0;
			max_y_n = '0;
			total_n = '0;
		end else if (ins_new) begin
			total_n = total_q + TOTAL_W'(1);
			if (total_q == '0) begin
				min_x_n = xi;
				max_x_n = xi;
				min_y_n = yi;
				max_y_n = yi;
			end else begin
				if (xi < min_x_q) min_x_n = xi;
				if (xi > max_x_q) max_x_n = xi;
				if (yi < min_y_q) min_y_n = yi;
				if (yi > max_y_q) max_y_n = yi;
			end
		end else if (rem_hit) begin
			total_n = total_q - TOTAL_W'(1);
			if (col_dec == '0) begin
				if (xi == min_x_q) min_x_n = col_lo;
				else if (xi == max_x_q) max_x_n = col_hi;
			end
			if (row_dec == '0) begin
				if (yi == min_y_q) min_y_n = row_lo;
				else if (yi == max_y_q) max_y_n = row_hi;
			end
		end

		res_n.found       = found;
		res_n.read_value  = !addressed ? '0 : (found ? dram_rdata : absent_q);
		res_n.min_x       = COORD_W'(min_x_n);
		res_n.max_x       = COORD_W'(max_x_n);
		res_n.min_y       = COORD_W'(min_y_n);
		res_n.max_y       = COORD_W'(max_y_n);
		res_n.is_empty    = (total_n == '0);
		res_n.range_error = (op_q.kind == OPK_RANGE);
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_op;
		end
		if (exec) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			absent_q    <= '0;
			row_ok_q    <= '0;
			min_x_q     <= '0;
			max_x_q     <= '0;
			min_y_q     <= '0;
			max_y_q     <= '0;
			total_q     <= '0;
			for (int i = 0; i < GRID_W; i++) col_cnt_q[i] <= '0;
			for (int i = 0; i < GRID_H; i++) row_cnt_q[i] <= '0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				absent_q <= cfg_wdata;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (exec) begin
				min_x_q <= min_x_n;
				max_x_q <= max_x_n;
				min_y_q <= min_y_n;
				max_y_q <= max_y_n;
				total_q <= total_n;
				if (wipe) begin
					row_ok_q <= '0;
					for (int i = 0; i < GRID_W; i++) col_cnt_q[i] <= '0;
					for (int i = 0; i < GRID_H; i++) row_cnt_q[i] <= '0;
				end else if (ins_new) begin
					row_ok_q[yi]  <= 1'b1;
					col_cnt_q[xi] <= col_cnt_q[xi] + COL_CW'(1);
					row_cnt_q[yi] <= row_cnt_q[yi] + ROW_CW'(1);
				end else if (rem_hit) begin
					row_ok_q[yi]  <= 1'b1;
					col_cnt_q[xi] <= col_dec;
					row_cnt_q[yi] <= row_dec;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign res      = res_q;
endmodule

// ----- rtl/sparse_grid_bounding_box_store_unit.sv -----
// Sparse grid store with occupancy counts and bounding box: top level.
//
// Input stream s_*: one request per beat carrying a command (insert/update,
// remove, lookup, clear all), a cell coordinate and a value word. Output
// stream m_*: exactly one result per request, in order: the addressed cell
// as it was before the request, and the bounding box and empty flag after it.
// cfg_we/cfg_wdata write the value reported for absent cells; write it only
// while no request is in flight.
//
// A request is accepted into a two-entry queue; the back end takes one
// request at a time, reading the cell tables as it pops the request and
// writing the update in the next cycle. An accepted request reaches
// m_tvalid through the queue, op_q and the result register.
// A stalled receiver holds the result register; the queue keeps accepting
// until it is full, then s_tready drops.
// Reset empties the grid at once (row valid flags clear), zeros the box and
// sets the absent value to zero; no sweep of the tables is needed.
module sparse_grid_bounding_box_store_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// command[1:0], x_coord[6:2], y_coord[11:7], write_value[43:12], zero pad
	input  logic [sgbb_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// found[0], read_value[32:1], min_x[37:33], max_x[42:38], min_y[47:43],
	// max_y[52:48], is_empty[53], range_error[54], zero pad
	output logic [sgbb_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                 cfg_we,
	input  logic [sgbb_pkg::VALUE_W-1:0]         cfg_wdata
);
	import sgbb_pkg::*;

	logic    q_valid;
	logic    q_pop;
	op_t     q_op;
	result_t res;

	sgbb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_pop    (q_pop)
	);

	sgbb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.q_pop     (q_pop),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res       (res)
	);

	assign m_tdata = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res};
endmodule

// ----- rtl/sgbb_checker.sv -----
// Port-level checks for the sparse grid store, bound to the top level.
module sgbb_props (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [sgbb_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import sgbb_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[53] |-> (m_tdata[52:33] == '0))
		else $error("empty store reports nonzero box");

	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[53] |->
			(m_tdata[37:33] <= m_tdata[42:38]) && (m_tdata[47:43] <= m_tdata[52:48]))
		else $error("box edges out of order");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[54] |-> !m_tdata[0] && (m_tdata[32:1] == '0))
		else $error("range error with cell data");
endmodule

bind sparse_grid_bounding_box_store_unit sgbb_props u_sgbb_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- test/sgbb_checker.sv -----
// Checker for the grid store: predicts each result from accepted requests and compares.
`timescale 1ns / 100ps
module sgbb_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [sgbb_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [sgbb_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             cfg_we,
	input  logic [sgbb_pkg::VALUE_W-1:0]     cfg_wdata,
	output int                               mismatches,
	output int                               results_owed
);
	import sgbb_pkg::*;

	logic [VALUE_W-1:0] absent_word;
	bit                 occupied [CELLS];
	logic [VALUE_W-1:0] stored [CELLS];
	int                 col_cnt [GRID_W];
	int                 row_cnt [GRID_H];
	logic [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
	int                 total;
	result_t            owed_results [$];

	assign results_owed = owed_results.size();

	function automatic void empty_grid();
		foreach (occupied[i]) occupied[i] = 0;
		foreach (col_cnt[i]) col_cnt[i] = 0;
		foreach (row_cnt[i]) row_cnt[i] = 0;
		lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
		total = 0;
	endfunction

	// lowest or highest nonzero index of a count array
	function automatic logic [COORD_W-1:0] edge_of(input int cnt [32], input bit want_high);
		logic [COORD_W-1:0] hit;
		hit = 0;
		for (int i = 0; i < 32; i++) begin
			if (cnt[i] != 0) begin
				hit = COORD_W'(i);
				if (!want_high) break;
			end
		end
		return hit;
	endfunction

	function automatic result_t apply_request(input logic [IN_TDATA_W-1:0] req);
		cmd_t               cmd;
		logic [COORD_W-1:0] x, y;
		logic [VALUE_W-1:0] wval;
		int                 idx;
		result_t            r;
		cmd = cmd_t'(req[1:0]);
		x = req[6:2];
		y = req[11:7];
		wval = req[43:12];
		r = '0;
		if (cmd == CMD_CLEAR) begin
			empty_grid();
		end else if (x >= GRID_W || y >= GRID_H) begin
			r.range_error = 1;
		end else begin
			idx = y * GRID_W + x;
			r.found = occupied[idx];
			r.read_value = occupied[idx] ? stored[idx] : absent_word;
			if (cmd == CMD_INSERT) begin
				if (!occupied[idx]) begin
					if (total == 0) begin
						lo_x = x; hi_x = x; lo_y = y; hi_y = y;
					end
					if (x < lo_x) lo_x = x;
					else if (x > hi_x) hi_x = x;
					if (y < lo_y) lo_y = y;
					else if (y > hi_y) hi_y = y;
					col_cnt[x]++;
					row_cnt[y]++;
					total++;
					occupied[idx] = 1;
				end
				stored[idx] = wval;
			end else if (cmd == CMD_REMOVE && occupied[idx]) begin
				occupied[idx] = 0;
				total--;
				if (total == 0) begin
					empty_grid();
				end else begin
					col_cnt[x]--;
					row_cnt[y]--;
					if (col_cnt[x] == 0) begin
						if (x == lo_x) lo_x = edge_of(col_cnt, 0);
						else if (x == hi_x) hi_x = edge_of(col_cnt, 1);
					end
					if (row_cnt[y] == 0) begin
						if (y == lo_y) lo_y = edge_of(row_cnt, 0);
						else if (y == hi_y) hi_y = edge_of(row_cnt, 1);
					end
				end
			end
		end
		r.min_x = lo_x;
		r.max_x = hi_x;
		r.min_y = lo_y;
		r.max_y = hi_y;
		r.is_empty = (total == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			absent_word = 0;
			empty_grid();
			owed_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) absent_word = cfg_wdata;
			if (s_tvalid && s_tready)
				owed_results.insert(owed_results.size(), apply_request(s_tdata));
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result %h", $realtime, got);
				end else begin
					want = owed_results.pop_front();
					if (got.found !== want.found || got.read_value !== want.read_value ||
							got.min_x !== want.min_x || got.max_x !== want.max_x ||
							got.min_y !== want.min_y || got.max_y !== want.max_y ||
							got.is_empty !== want.is_empty ||
							got.range_error !== want.range_error) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch exp f=%b v=%h x=%0d..%0d y=%0d..%0d e=%b r=%b got f=%b v=%h x=%0d..%0d y=%0d..%0d e=%b r=%b",
								$realtime, want.found, want.read_value, want.min_x,
								want.max_x, want.min_y, want.max_y, want.is_empty,
								want.range_error, got.found, got.read_value, got.min_x,
								got.max_x, got.min_y, got.max_y, got.is_empty,
								got.range_error);
					end
				end
			end
		end
	end

endmodule

// ----- test/testbench.sv -----
// Top of the grid store testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
	import sgbb_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic [VALUE_W-1:0]     cfg_wdata;
	int                     mismatches;
	int                     results_owed;
	bit                     quiet;
	int                     cycles;

	sparse_grid_bounding_box_store_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	sgbb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.results_owed(results_owed)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 300000) begin
				$display("FAIL sparse_grid_bounding_box_store_unit");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, one long hold-off early on, none once quiet
	initial begin
		int n;
		m_tready = 0;
		n = 0;
		@(posedge arst_n);
		forever begin
			n++;
			if (n == 40) begin
				m_tready <= 0;
				repeat (200) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_tready <= 1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	task automatic send_request(input cmd_t cmd, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [VALUE_W-1:0] wval);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {4'b0, wval, y, x, cmd};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_absent(input logic [VALUE_W-1:0] word);
		s_tvalid <= 0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= word;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic random_request(input bit narrow);
		cmd_t               cmd;
		int                 pick;
		logic [COORD_W-1:0] x, y;
		pick = $urandom_range(0, 99);
		if (pick < 40) cmd = CMD_INSERT;
		else if (pick < 72) cmd = CMD_REMOVE;
		else if (pick < 98) cmd = CMD_LOOKUP;
		else cmd = CMD_CLEAR;
		// a small window keeps removes hitting stored cells
		if (narrow) begin
			x = COORD_W'($urandom_range(0, 5) + (pick[0] ? 26 : 0));
			y = COORD_W'($urandom_range(0, 5) + (pick[1] ? 26 : 0));
		end else begin
			x = COORD_W'($urandom);
			y = COORD_W'($urandom);
		end
		send_request(cmd, x, y, $urandom);
	endtask

	initial begin
		logic [VALUE_W-1:0] words [4];
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		quiet = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_absent(32'hFFFF_FFFF);
		send_request(CMD_LOOKUP, 0, 0, 0);
		send_request(CMD_REMOVE, 31, 31, 0);
		send_request(CMD_INSERT, 5, 7, 32'h0000_0000);
		send_request(CMD_INSERT, 0, 0, 32'hFFFF_FFFF);
		send_request(CMD_INSERT, 31, 31, 32'h3F80_0000);
		send_request(CMD_INSERT, 0, 31, 32'h8000_0001);
		send_request(CMD_INSERT, 31, 0, 32'h1234_5678);
		send_request(CMD_INSERT, 0, 0, 32'hDEAD_BEEF);
		send_request(CMD_LOOKUP, 0, 0, 0);
		send_request(CMD_LOOKUP, 15, 16, 0);
		send_request(CMD_REMOVE, 0, 0, 0);
		send_request(CMD_REMOVE, 0, 31, 0);
		send_request(CMD_REMOVE, 31, 31, 0);
		send_request(CMD_REMOVE, 31, 31, 0);
		send_request(CMD_REMOVE, 31, 0, 0);
		send_request(CMD_REMOVE, 5, 7, 0);
		send_request(CMD_INSERT, 10, 20, 32'hAAAA_5555);
		send_request(CMD_INSERT, 21, 10, 32'h5555_AAAA);
		send_request(CMD_CLEAR, 31, 31, 32'hFFFF_FFFF);
		send_request(CMD_LOOKUP, 10, 20, 0);
		send_request(CMD_INSERT, 3, 3, 32'h0000_0001);

		words[0] = 32'h0000_0000;
		words[1] = $urandom;
		words[2] = 32'hFFFF_FFFF;
		words[3] = $urandom;
		for (int phase = 0; phase < 4; phase++) begin
			write_absent(words[phase]);
			if (phase == 3) quiet = 1;
			for (int i = 0; i < 170; i++) random_request($urandom_range(0, 3) != 0);
		end
		s_tvalid <= 0;

		while (results_owed != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && results_owed == 0)
			$display("PASS sparse_grid_bounding_box_store_unit");
		else
			$display("FAIL sparse_grid_bounding_box_store_unit");
		$finish;
	end

endmodule

// ----- sparse_grid_bounding_box_store_unit.f -----
rtl/sgbb_pkg.sv
rtl/sgbb_ram.sv
rtl/sgbb_front.sv
rtl/sgbb_back.sv
rtl/sparse_grid_bounding_box_store_unit.sv
rtl/sgbb_checker.sv
test/sgbb_checker.sv
test/testbench.sv
